### rtl/core/feba_pkg.sv
// Package for the element-wise binary32 ALU: action codes, constants, item types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package feba_pkg;
    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_MAX = 2'd3
    } t_action;

    localparam logic [31:0] QNAN_CANON = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG    = 31'h7F80_0000;

    // Pre-rounding form handed from the datapath to the rounder:
    // value = sig * 2^(exp - 26), sig normalized so bit 26 is set unless sig==0.
    typedef struct packed {
        logic        special;   // result already final in bits
        logic [31:0] bits;
        logic        sign;
        logic signed [10:0] exp;
        logic [26:0] sig;
    } t_pre;
endpackage
`default_nettype wire

### rtl/core/feba_round.sv
// Rounding and packing stage pair for the binary32 ALU (RNE, subnormal, overflow).
// Depends on feba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module feba_round (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    input  wire feba_pkg::t_pre i_pre,
    output logic                o_vld,
    output logic [31:0]         o_bits
);
    import feba_pkg::*;

    // stage 1: denormalize shift
    logic        r_vld1, r_spec1, r_sign1;
    logic [31:0] r_bits1;
    logic [26:0] r_sig1;
    logic [7:0]  r_be1;
    logic signed [11:0] be;
    logic [5:0]  sh;
    logic [26:0] dsig;
    logic        stk;

    always_comb begin
        be = 12'(i_pre.exp) + 12'sd127;
        sh = 6'd0;
        if (be < 12'sd1) sh = (be < -12'sd30) ? 6'd31 : 6'(12'sd1 - be);
        dsig = i_pre.sig >> sh;
        stk  = |(i_pre.sig & ~(27'h7FF_FFFF << sh));
        dsig[0] = dsig[0] | stk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld1 <= 1'b0;
        else          r_vld1 <= i_vld;
        r_spec1 <= i_pre.special;
        r_bits1 <= i_pre.bits;
        r_sign1 <= i_pre.sign;
        r_sig1  <= dsig;
        if (be < 12'sd1)        r_be1 <= 8'd0;
        else if (be > 12'sd254) r_be1 <= 8'd255;
        else                    r_be1 <= be[7:0];
    end

    // stage 2: round and pack
    logic [24:0] rs;
    logic [2:0]  rb;
    logic [8:0]  e2;
    logic [31:0] n_bits;

    always_comb begin
        rb = r_sig1[2:0];
        rs = {1'b0, r_sig1[26:3]};
        if (rb > 3'd4 || (rb == 3'd4 && rs[0])) rs = rs + 25'd1;
        e2 = {1'b0, r_be1};
        if (r_be1 == 8'd0) begin
            // subnormal; carry into bit 23 yields min normal naturally
            n_bits = {r_sign1, 8'd0, 23'd0} | {8'd0, rs[23:0]};
        end else begin
            if (rs[24]) begin
                rs = rs >> 1;
                e2 = e2 + 9'd1;
            end
            if (e2 >= 9'd255) n_bits = {r_sign1, INF_MAG};
            else              n_bits = {r_sign1, e2[7:0], rs[22:0]};
        end
        if (r_spec1) n_bits = r_bits1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_vld <= 1'b0;
        else          o_vld <= r_vld1;
        o_bits <= n_bits;
    end
endmodule
`default_nettype wire

### rtl/core/float_elementwise_binary_alu.sv
// Top level of the element-wise binary32 ALU: add, subtract, guarded multiply, maximum.
// Registered through stages 1-3 and feba_round; one transaction accepted every cycle.
// busy is always low; the receiver cannot stall, results strobe for one cycle.
// Synchronous active-low reset clears the valid pipeline; payload is not reset.
// Depends on feba_pkg and feba_round.
`timescale 1ns / 1ps
`default_nettype none
module float_elementwise_binary_alu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_operand_a,
    input  wire logic [31:0] i_operand_b,
    output logic             o_valid,
    output logic [31:0]      o_result
);
    import feba_pkg::*;

    assign busy = 1'b0;
    logic acc;
    assign acc = start && !busy;

    // ---- stage 1: classify, swap, special results
    function automatic logic f_nan(input logic [31:0] x);
        return x[30:0] > INF_MAG;
    endfunction
    function automatic logic f_inf(input logic [31:0] x);
        return x[30:0] == INF_MAG;
    endfunction

    logic [31:0] a, b, big, sml;
    logic        spec, gt, is_mul;
    logic [31:0] sbits;
    always_comb begin
        a = i_operand_a;
        b = (t_action'(i_action) == ACT_SUB) ? {~i_operand_b[31], i_operand_b[30:0]}
                                             : i_operand_b;
        is_mul = (t_action'(i_action) == ACT_MUL);
        gt = 1'b0;
        if (!f_nan(a) && !f_nan(b) && (a[30:0] != 0 || b[30:0] != 0)) begin
            if (a[31] != b[31]) gt = !a[31];
            else if (!a[31])    gt = a[30:0] > b[30:0];
            else                gt = a[30:0] < b[30:0];
        end
        spec = 1'b1;
        sbits = QNAN_CANON;
        case (t_action'(i_action))
            ACT_MAX: sbits = gt ? a : b;
            ACT_MUL: begin
                if (a[30:0] == 0 || b[30:0] == 0) sbits = 32'd0;
                else if (f_nan(a) || f_nan(b))    sbits = QNAN_CANON;
                else if (f_inf(a) || f_inf(b))    sbits = {a[31] ^ b[31], INF_MAG};
                else                              spec = 1'b0;
            end
            default: begin
                if (f_nan(a) || f_nan(b))       sbits = QNAN_CANON;
                else if (f_inf(a) && f_inf(b))  sbits = (a[31] == b[31]) ? a : QNAN_CANON;
                else if (f_inf(a))              sbits = a;
                else if (f_inf(b))              sbits = b;
                else                            spec = 1'b0;
            end
        endcase
        if (a[30:0] >= b[30:0]) begin
            big = a; sml = b;
        end else begin
            big = b; sml = a;
        end
    end

    logic        r_v1, r_spec1, r_mul1;
    logic [31:0] r_bits1, r_big1, r_sml1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= acc;
        r_spec1 <= spec;
        r_mul1  <= is_mul;
        r_bits1 <= sbits;
        r_big1  <= is_mul ? a : big;
        r_sml1  <= is_mul ? b : sml;
    end

    // ---- stage 2: align+add, or multiply
    logic [7:0]  eb, es;
    logic [23:0] mb, ms;
    logic [8:0]  ed;
    logic [50:0] al;
    logic [51:0] sum;
    logic [47:0] prod;
    logic        sub;
    always_comb begin
        eb = (r_big1[30:23] == 0) ? 8'd1 : r_big1[30:23];
        es = (r_sml1[30:23] == 0) ? 8'd1 : r_sml1[30:23];
        mb = {r_big1[30:23] != 0, r_big1[22:0]};
        ms = {r_sml1[30:23] != 0, r_sml1[22:0]};
        ed = {1'b0, eb} - {1'b0, es};
        // keep 27 guard bits below sig, sticky in bit 0
        if (ed > 9'd50) al = {50'd0, ms != 0};
        else begin
            al = {ms, 27'd0} >> ed[5:0];
            al[0] = al[0] | |({ms, 27'd0} & ~(51'h7_FFFF_FFFF_FFFF << ed[5:0]));
        end
        sub = r_big1[31] != r_sml1[31];
        sum = sub ? ({1'b0, mb, 27'd0} - {1'b0, al}) : ({1'b0, mb, 27'd0} + {1'b0, al});
        prod = mb * ms;
    end

    logic        r_v2, r_spec2, r_sign2;
    logic [31:0] r_bits2;
    logic [51:0] r_sum2;
    logic signed [10:0] r_exp2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_spec2 <= r_spec1;
        r_bits2 <= r_bits1;
        if (!r_mul1 && !r_spec1 && ((sub && sum == 0) || mb == 0 && ms == 0)) begin
            r_spec2 <= 1'b1;
            r_bits2 <= sub ? 32'd0 : {r_big1[31], 31'd0};
        end
        if (r_mul1) begin
            r_sum2  <= {4'd0, prod};
            r_sign2 <= r_big1[31] ^ r_sml1[31];
            r_exp2  <= 11'(eb) + 11'(es) - 11'sd300 + 11'sd26;
        end else begin
            // sum carries the significand scaled by 2^27
            r_sum2  <= sum;
            r_sign2 <= r_big1[31];
            r_exp2  <= 11'(eb) - 11'sd177 + 11'sd26;
        end
    end

    // ---- stage 3: normalize to 27 bits (bit 26 leading)
    logic [5:0]  lz;
    logic [51:0] nrm;
    logic        found;
    t_pre        pre;
    always_comb begin
        lz = 6'd0;
        found = 1'b0;
        for (int i = 51; i >= 0; i--) begin
            if (!found && r_sum2[i]) begin
                lz = 6'(51 - i);
                found = 1'b1;
            end
        end
        nrm = r_sum2 << lz;
        pre.special = r_spec2;
        pre.bits    = r_bits2;
        pre.sign    = r_sign2;
        pre.sig     = {nrm[51:26], |nrm[25:0]};
        // value = sum*2^(exp-26); leading at 51-lz => exponent exp-26+51-lz
        pre.exp     = r_exp2 + 11'sd25 - 11'(lz);
    end

    t_pre r_pre3;
    logic r_v3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
        r_pre3 <= pre;
    end

    feba_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v3),
        .i_pre   (r_pre3),
        .o_vld   (o_valid),
        .o_bits  (o_result)
    );

    // ---- checks
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_v1) else $error("stage 1 valid lost");
    a_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |=> ##2 o_valid) else $error("valid lost in pipeline");
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v3 |=> ##1 !o_valid) else $error("spurious result strobe");
endmodule
`default_nettype wire
